[rtl/core/assert_macros.svh]
// Assertion macros shared by the message FIFO queue modules.
// Depends on nothing; each user module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define MFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define MFQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mfq_pkg.sv]
// Shared types and constants of the message FIFO queue.
// Used by mfq_ctrl, mfq_datapath and message_fifo_queue; depends on nothing.
package mfq_pkg;

  // Fixed field widths of the words on the ports.
  localparam int LEN_W  = 7;
  localparam int CAP_W  = 12;
  localparam int BYTE_W = 8;

  // Operation carried by an input word.
  typedef enum logic {
    ACT_PUT = 1'b0,
    ACT_GET = 1'b1
  } act_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_SMALL = 3'd4,
    ST_DATA      = 3'd5
  } status_t;

  typedef struct packed {
    act_t              action;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [CAP_W-1:0]  out_capacity;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_run;
    logic [LEN_W-1:0]  message_length;
    logic [LEN_W-1:0]  messages_held;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic put_go;
    logic get_go;
    logic emit_empty;
    logic emit_small;
    logic stream_start;
    logic byte_read;
    logic byte_emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic msg_empty;
    logic cap_short;
    logic last_in_msg;
  } dp_stat_t;

endpackage

[rtl/core/message_fifo_queue.sv]
// Channel   Ports                          Carries
// input     in_valid, in_stall, in_word    put byte or get request
// result    out_valid, out_stall, out_word status, stream byte, counts
//
// Put words are taken at one word per cycle while the result channel does not stall.
// A get first checks the head length in the check state, then streams each byte as
// one byte-store read whose data is registered, then one load of the output register.
// Empty and too-small answers are loaded from the check state.
// Reset is synchronous and clears pointers and counters; stores need no clear.
// A stalled result holds the output register, and the input stalls behind it.
// Top level of the message FIFO queue; depends on mfq_pkg, mfq_ctrl, mfq_datapath.
module message_fifo_queue #(
  parameter int MAX_MSG_BYTES = 64,
  parameter int STORE_BYTES   = 1024,
  parameter int MAX_MSGS      = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mfq_pkg::out_word_t out_word
);

  mfq_pkg::ctrl_cmd_t cmd;
  mfq_pkg::dp_stat_t  stat;

  // Sequencing of put and get words.
  mfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_word.action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, pointers and result register.
  mfq_datapath #(
    .MAX_MSG_BYTES (MAX_MSG_BYTES),
    .STORE_BYTES   (STORE_BYTES),
    .MAX_MSGS      (MAX_MSGS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[rtl/core/mfq_ctrl.sv]
// Controller state machine of the message FIFO queue.
// Depends on mfq_pkg and assert_macros.svh; drives commands to mfq_datapath.
`include "assert_macros.svh"

module mfq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  mfq_pkg::act_t      in_action,
  output logic               in_stall,
  input  mfq_pkg::dp_stat_t  stat,
  output mfq_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Words are taken only in idle, and only when the output register can load.
  assign in_stall = !((state_r == ST_IDLE) && stat.slot_free);
  assign accept   = in_valid && !in_stall;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == mfq_pkg::ACT_PUT) begin
            cmd.put_go = 1'b1;
          end else begin
            cmd.get_go = 1'b1;
            state_nxt  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat.slot_free) begin
          if (stat.msg_empty) begin
            cmd.emit_empty = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (stat.cap_short) begin
            cmd.emit_small = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.stream_start = 1'b1;
            state_nxt        = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.byte_read = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.byte_emit = 1'b1;
          state_nxt     = stat.last_in_msg ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A synchronous reset leaves the machine idle.
  `MFQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE), "not idle after reset")
  // The final byte of a message returns the machine to idle.
  `MFQ_ASSERT(a_last_to_idle, (cmd.byte_emit && stat.last_in_msg) |=> (state_r == ST_IDLE),
              "stream did not end on last byte")

endmodule

[rtl/core/mfq_datapath.sv]
// Datapath of the message FIFO queue: byte store, length ring, pointers, counters
// and the output register. Depends on mfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfq_datapath #(
  parameter int MAX_MSG_BYTES = 64,
  parameter int STORE_BYTES   = 1024,
  parameter int MAX_MSGS      = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfq_pkg::in_word_t   in_word,
  input  mfq_pkg::ctrl_cmd_t  cmd,
  output mfq_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_stall,
  output mfq_pkg::out_word_t  out_word
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int UW = $clog2(STORE_BYTES + 1);
  localparam int RW = $clog2(MAX_MSGS);
  localparam int CW = $clog2(MAX_MSGS + 1);
  localparam int LW = mfq_pkg::LEN_W;

  // Memories.
  logic [mfq_pkg::BYTE_W-1:0] byte_store [STORE_BYTES];
  logic [LW-1:0]              length_ring [MAX_MSGS];

  // Control state.
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]     cw_ptr_r, cw_ptr_nxt;
  logic [AW-1:0]     pw_ptr_r, pw_ptr_nxt;
  logic [LW-1:0]     pend_len_r, pend_len_nxt;
  mfq_pkg::status_t  pend_rej_r, pend_rej_nxt;
  logic [RW-1:0]     head_r, head_nxt;
  logic [RW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [UW-1:0]     used_r, used_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [mfq_pkg::CAP_W-1:0]  cap_r;
  logic [LW-1:0]              len_r;
  logic [LW-1:0]              ring_rd_r;
  logic [mfq_pkg::BYTE_W-1:0] byte_rd_r;
  mfq_pkg::out_word_t         out_word_r, out_word_nxt;

  // Put evaluation.
  logic [AW-1:0]    pw_inc;
  logic [UW:0]      fill_sum;
  logic             put_wr;
  logic             put_commit;
  logic [LW-1:0]    put_len;
  logic [AW-1:0]    put_wp;
  mfq_pkg::status_t put_rej;
  logic             load;

  assign pw_inc   = (pw_ptr_r == AW'(STORE_BYTES - 1)) ? '0 : pw_ptr_r + AW'(1);
  assign fill_sum = {1'b0, used_r} + (UW + 1)'(pend_len_r) + (UW + 1)'(1);

  // One put word: store the byte unless the message is already rejected or this byte is rejected.
  always_comb begin
    put_rej = pend_rej_r;
    put_wr  = 1'b0;
    put_len = pend_len_r;
    put_wp  = pw_ptr_r;
    if (pend_rej_r == mfq_pkg::ST_OK) begin
      if (pend_len_r >= LW'(MAX_MSG_BYTES)) begin
        put_rej = mfq_pkg::ST_TOO_LARGE;
      end else if (fill_sum > (UW + 1)'(STORE_BYTES)) begin
        put_rej = mfq_pkg::ST_NO_ROOM;
      end else begin
        put_wr  = 1'b1;
        put_wp  = pw_inc;
        put_len = pend_len_r + LW'(1);
      end
    end
    if (in_word.last_byte && (put_rej == mfq_pkg::ST_OK) &&
        (count_r >= CW'(MAX_MSGS))) begin
      put_rej = mfq_pkg::ST_NO_ROOM;
    end
    put_commit = in_word.last_byte && (put_rej == mfq_pkg::ST_OK);
  end

  // Status toward the controller.
  assign stat.slot_free   = !out_valid_r || !out_stall;
  assign stat.msg_empty   = (count_r == '0);
  assign stat.cap_short   = (cap_r < mfq_pkg::CAP_W'(ring_rd_r));
  assign stat.last_in_msg = ((idx_r + LW'(1)) == len_r);

  // Next values of pointers and counters.
  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    cw_ptr_nxt   = cw_ptr_r;
    pw_ptr_nxt   = pw_ptr_r;
    pend_len_nxt = pend_len_r;
    pend_rej_nxt = pend_rej_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    used_nxt     = used_r;
    idx_nxt      = idx_r;
    if (cmd.put_go) begin
      if (in_word.last_byte) begin
        if (put_commit) begin
          tail_nxt   = (tail_r == RW'(MAX_MSGS - 1)) ? '0 : tail_r + RW'(1);
          count_nxt  = count_r + CW'(1);
          used_nxt   = used_r + UW'(put_len);
          cw_ptr_nxt = put_wp;
          pw_ptr_nxt = put_wp;
        end else begin
          pw_ptr_nxt = cw_ptr_r;
        end
        pend_len_nxt = '0;
        pend_rej_nxt = mfq_pkg::ST_OK;
      end else begin
        pw_ptr_nxt   = put_wp;
        pend_len_nxt = put_len;
        pend_rej_nxt = put_rej;
      end
    end
    // The head message leaves the queue as its stream begins.
    if (cmd.stream_start) begin
      head_nxt  = (head_r == RW'(MAX_MSGS - 1)) ? '0 : head_r + RW'(1);
      count_nxt = count_r - CW'(1);
      used_nxt  = used_r - UW'(ring_rd_r);
      idx_nxt   = '0;
    end
    if (cmd.byte_read) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(STORE_BYTES - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (cmd.byte_emit) begin
      idx_nxt = idx_r + LW'(1);
    end
  end

  // Output word selection.
  always_comb begin
    out_word_nxt = out_word_r;
    load         = 1'b1;
    if (cmd.put_go) begin
      out_word_nxt.status         = put_rej;
      out_word_nxt.out_byte       = '0;
      out_word_nxt.end_of_run     = 1'b1;
      out_word_nxt.message_length = (put_rej == mfq_pkg::ST_OK) ? put_len : '0;
      out_word_nxt.messages_held  = LW'(count_nxt);
    end else if (cmd.emit_empty) begin
      out_word_nxt.status         = mfq_pkg::ST_EMPTY;
      out_word_nxt.out_byte       = '0;
      out_word_nxt.end_of_run     = 1'b1;
      out_word_nxt.message_length = '0;
      out_word_nxt.messages_held  = LW'(count_r);
    end else if (cmd.emit_small) begin
      out_word_nxt.status         = mfq_pkg::ST_TOO_SMALL;
      out_word_nxt.out_byte       = '0;
      out_word_nxt.end_of_run     = 1'b1;
      out_word_nxt.message_length = ring_rd_r;
      out_word_nxt.messages_held  = LW'(count_r);
    end else if (cmd.byte_emit) begin
      out_word_nxt.status         = mfq_pkg::ST_DATA;
      out_word_nxt.out_byte       = byte_rd_r;
      out_word_nxt.end_of_run     = stat.last_in_msg;
      out_word_nxt.message_length = len_r;
      out_word_nxt.messages_held  = LW'(count_r);
    end else begin
      load = 1'b0;
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      cw_ptr_r    <= '0;
      pw_ptr_r    <= '0;
      pend_len_r  <= '0;
      pend_rej_r  <= mfq_pkg::ST_OK;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      used_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      cw_ptr_r    <= cw_ptr_nxt;
      pw_ptr_r    <= pw_ptr_nxt;
      pend_len_r  <= pend_len_nxt;
      pend_rej_r  <= pend_rej_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.get_go) begin
      cap_r <= in_word.out_capacity;
    end
    if (cmd.stream_start) begin
      len_r <= ring_rd_r;
    end
    if (load) begin
      out_word_r <= out_word_nxt;
    end
  end

  // Byte store: one write port for puts, one registered read port for streaming.
  always_ff @(posedge clk) begin
    if (cmd.put_go && put_wr) begin
      byte_store[pw_ptr_r] <= in_word.data_byte;
    end
    if (cmd.byte_read) begin
      byte_rd_r <= byte_store[rd_ptr_r];
    end
  end

  // Length ring: written on commit, read at the head every cycle.
  always_ff @(posedge clk) begin
    if (cmd.put_go && put_commit) begin
      length_ring[tail_r] <= put_len;
    end
    ring_rd_r <= length_ring[head_r];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Committed plus pending bytes never overrun the store.
  `MFQ_ASSERT(a_store_fill, fill_sum <= (UW + 1)'(STORE_BYTES + 1), "store overfilled")
  // An empty queue holds no committed bytes.
  `MFQ_ASSERT(a_empty_no_bytes, (count_r == '0) |-> (used_r == '0), "bytes held with no message")
  // A stream starts only on a queued message that fits the reader.
  `MFQ_ASSERT(a_stream_ok, cmd.stream_start |-> (!stat.msg_empty && !stat.cap_short),
              "stream started on empty queue or short reader")

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for the message FIFO queue: directed rows, a ring fill and drain, then random traffic.
// Depends on mfq_pkg and message_fifo_queue; expected words come from a local predictor.
module testbench;

  localparam int MSG_MAX      = 64;
  localparam int STORE_SIZE   = 1024;
  localparam int RING_SIZE    = 64;
  localparam int ITEM_TARGET  = 330;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 16;
  localparam int REPORT_LIMIT = 10;
  localparam int DIR_ROWS     = 18;

  // One input word waiting to be sent, with an optional hand-written answer.
  typedef struct packed {
    mfq_pkg::in_word_t  word;
    logic               has_fixed;
    mfq_pkg::out_word_t fixed_resp;
  } stim_item_t;

  // One row of the directed table.
  typedef struct packed {
    mfq_pkg::act_t    act;
    logic [7:0]       data;
    logic             last;
    logic [11:0]      cap;
    logic             fixed;
    mfq_pkg::status_t st;
    logic [7:0]       obyte;
    logic [6:0]       len;
    logic [6:0]       held;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  mfq_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  mfq_pkg::out_word_t out_word;

  stim_item_t         send_queue[$];
  mfq_pkg::out_word_t awaited_responses[$];
  dir_row_t           directed_rows [DIR_ROWS];

  int words_taken;
  int total_words;
  int quiet_cycles;
  int error_count;

  // Mirror of the queue contents and pointers.
  logic [7:0]       fifo_bytes [STORE_SIZE];
  logic [6:0]       fifo_lengths [RING_SIZE];
  int               read_addr;
  int               commit_addr;
  int               build_addr;
  int               build_len;
  mfq_pkg::status_t build_reject;
  int               head_slot;
  int               tail_slot;
  int               held_msgs;
  int               bytes_in_use;

  message_fifo_queue #(
    .MAX_MSG_BYTES(MSG_MAX),
    .STORE_BYTES(STORE_SIZE),
    .MAX_MSGS(RING_SIZE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out the result words that one accepted input word causes.
  task automatic compute_fifo_response(input mfq_pkg::in_word_t w);
    mfq_pkg::out_word_t r;
    int                 len;
    r = '0;
    r.end_of_run = 1'b1;
    if (w.action == mfq_pkg::ACT_PUT) begin
      if (build_reject == mfq_pkg::ST_OK) begin
        if (build_len + 1 > MSG_MAX) begin
          build_reject = mfq_pkg::ST_TOO_LARGE;
        end else if (bytes_in_use + build_len + 1 > STORE_SIZE) begin
          build_reject = mfq_pkg::ST_NO_ROOM;
        end else begin
          fifo_bytes[build_addr] = w.data_byte;
          build_addr = (build_addr + 1) % STORE_SIZE;
          build_len++;
        end
      end
      // A full length ring rejects the message on its last byte.
      if (w.last_byte && build_reject == mfq_pkg::ST_OK && held_msgs >= RING_SIZE)
        build_reject = mfq_pkg::ST_NO_ROOM;
      r.status = build_reject;
      r.message_length = (build_reject == mfq_pkg::ST_OK) ? mfq_pkg::LEN_W'(build_len) : '0;
      if (w.last_byte) begin
        if (build_reject == mfq_pkg::ST_OK) begin
          fifo_lengths[tail_slot] = mfq_pkg::LEN_W'(build_len);
          tail_slot = (tail_slot + 1) % RING_SIZE;
          held_msgs++;
          bytes_in_use += build_len;
          commit_addr = build_addr;
        end
        build_addr = commit_addr;
        build_len = 0;
        build_reject = mfq_pkg::ST_OK;
      end
      r.messages_held = mfq_pkg::LEN_W'(held_msgs);
      awaited_responses.push_back(r);
    end else if (held_msgs == 0) begin
      r.status = mfq_pkg::ST_EMPTY;
      awaited_responses.push_back(r);
    end else begin
      len = int'(fifo_lengths[head_slot]);
      if (w.out_capacity < len) begin
        r.status = mfq_pkg::ST_TOO_SMALL;
        r.message_length = mfq_pkg::LEN_W'(len);
        r.messages_held = mfq_pkg::LEN_W'(held_msgs);
        awaited_responses.push_back(r);
      end else begin
        // Stream the head message, then free it.
        held_msgs--;
        for (int i = 0; i < len; i++) begin
          r.status = mfq_pkg::ST_DATA;
          r.out_byte = fifo_bytes[read_addr];
          r.end_of_run = (i == len - 1);
          r.message_length = mfq_pkg::LEN_W'(len);
          r.messages_held = mfq_pkg::LEN_W'(held_msgs);
          awaited_responses.push_back(r);
          read_addr = (read_addr + 1) % STORE_SIZE;
        end
        bytes_in_use -= len;
        head_slot = (head_slot + 1) % RING_SIZE;
      end
    end
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic check_response(input mfq_pkg::out_word_t got);
    mfq_pkg::out_word_t want;
    if (awaited_responses.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: unexpected result word: status=%0d byte=%02h end=%0b len=%0d held=%0d",
                 $time, got.status, got.out_byte, got.end_of_run, got.message_length,
                 got.messages_held);
    end else begin
      want = awaited_responses.pop_front();
      if (got.status !== want.status || got.out_byte !== want.out_byte ||
          got.end_of_run !== want.end_of_run || got.message_length !== want.message_length ||
          got.messages_held !== want.messages_held) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: result mismatch, expected status=%0d byte=%02h end=%0b len=%0d held=%0d",
                   $time, want.status, want.out_byte, want.end_of_run, want.message_length,
                   want.messages_held);
          $display("%0t:                  actual   status=%0d byte=%02h end=%0b len=%0d held=%0d",
                   $time, got.status, got.out_byte, got.end_of_run, got.message_length,
                   got.messages_held);
        end
      end
    end
  endtask

  function automatic mfq_pkg::in_word_t make_put(input logic [7:0] b, input logic last);
    mfq_pkg::in_word_t w;
    w.action = mfq_pkg::ACT_PUT;
    w.data_byte = b;
    w.last_byte = last;
    w.out_capacity = mfq_pkg::CAP_W'($urandom_range(0, 4095));
    return w;
  endfunction

  function automatic mfq_pkg::in_word_t make_get(input int cap);
    mfq_pkg::in_word_t w;
    w.action = mfq_pkg::ACT_GET;
    w.data_byte = mfq_pkg::BYTE_W'($urandom_range(0, 255));
    w.last_byte = 1'($urandom_range(0, 1));
    w.out_capacity = mfq_pkg::CAP_W'(cap);
    return w;
  endfunction

  task automatic queue_word(input mfq_pkg::in_word_t w, input logic fixed,
                            input mfq_pkg::out_word_t resp);
    stim_item_t item;
    item.word = w;
    item.has_fixed = fixed;
    item.fixed_resp = resp;
    send_queue.push_back(item);
  endtask

  // A whole message of random bytes, optionally with a get slipped in after its first byte.
  task automatic queue_message(input int len, input bit mid_get);
    for (int i = 0; i < len; i++) begin
      queue_word(make_put(mfq_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1), 1'b0, '0);
      if (mid_get && i == 0 && len > 1)
        queue_word(make_get($urandom_range(0, 4095)), 1'b0, '0);
    end
  endtask

  task automatic queue_drain(input int count, input int cap);
    repeat (count) queue_word(make_get(cap), 1'b0, '0);
  endtask

  // Accept and check words, then present the next ones.
  always @(posedge clk) begin : drive_and_check
    stim_item_t item;
    bit         took;
    int         send_idle;
    int         recv_idle;
    int         first_new;
    if (rst_n) begin
      took = 1'b0;
      if (words_taken * 3 < total_words) begin
        send_idle = 38;
        recv_idle = 87;
      end else if (words_taken * 3 < total_words * 2) begin
        send_idle = 87;
        recv_idle = 38;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      if (in_valid && !in_stall) begin
        item = send_queue.pop_front();
        first_new = awaited_responses.size();
        compute_fifo_response(item.word);
        // Rows with a hand-written answer cause exactly one result word.
        if (item.has_fixed)
          awaited_responses[first_new] = item.fixed_resp;
        words_taken++;
        took = 1'b1;
      end

      if (out_valid && !out_stall) begin
        check_response(out_word);
        took = 1'b1;
      end

      // A stalled word stays on the port unchanged.
      if (!(in_valid && in_stall)) begin
        if (send_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid <= 1'b1;
          in_word <= send_queue[0].word;
        end else begin
          in_valid <= 1'b0;
        end
      end

      out_stall <= ($urandom_range(0, 99) < recv_idle);
      quiet_cycles = took ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    int                 pick;
    int                 sel;
    int                 len;
    int                 cap;
    mfq_pkg::in_word_t  w;
    mfq_pkg::out_word_t resp;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    words_taken = 0;
    total_words = 0;
    quiet_cycles = 0;
    error_count = 0;
    read_addr = 0;
    commit_addr = 0;
    build_addr = 0;
    build_len = 0;
    build_reject = mfq_pkg::ST_OK;
    head_slot = 0;
    tail_slot = 0;
    held_msgs = 0;
    bytes_in_use = 0;

    // Directed rows: empty queue, byte extremes, exact and short capacities,
    // and a get while a message is still being assembled.
    directed_rows = '{
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'hFFF, 1'b1, mfq_pkg::ST_EMPTY,     8'h00, 7'd0, 7'd0},
      '{mfq_pkg::ACT_PUT, 8'h00, 1'b1, 12'h000, 1'b1, mfq_pkg::ST_OK,        8'h00, 7'd1, 7'd1},
      '{mfq_pkg::ACT_GET, 8'hFF, 1'b1, 12'h000, 1'b1, mfq_pkg::ST_TOO_SMALL, 8'h00, 7'd1, 7'd1},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'h001, 1'b1, mfq_pkg::ST_DATA,      8'h00, 7'd1, 7'd0},
      '{mfq_pkg::ACT_PUT, 8'hFF, 1'b0, 12'hFFF, 1'b1, mfq_pkg::ST_OK,        8'h00, 7'd1, 7'd0},
      '{mfq_pkg::ACT_PUT, 8'hA5, 1'b0, 12'h000, 1'b1, mfq_pkg::ST_OK,        8'h00, 7'd2, 7'd0},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'hFFF, 1'b1, mfq_pkg::ST_EMPTY,     8'h00, 7'd0, 7'd0},
      '{mfq_pkg::ACT_PUT, 8'h5A, 1'b1, 12'h000, 1'b1, mfq_pkg::ST_OK,        8'h00, 7'd3, 7'd1},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'h002, 1'b1, mfq_pkg::ST_TOO_SMALL, 8'h00, 7'd3, 7'd1},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'h003, 1'b0, mfq_pkg::ST_DATA,      8'h00, 7'd0, 7'd0},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'hFFF, 1'b1, mfq_pkg::ST_EMPTY,     8'h00, 7'd0, 7'd0},
      '{mfq_pkg::ACT_PUT, 8'h80, 1'b1, 12'hAAA, 1'b1, mfq_pkg::ST_OK,        8'h00, 7'd1, 7'd1},
      '{mfq_pkg::ACT_PUT, 8'h01, 1'b1, 12'h555, 1'b1, mfq_pkg::ST_OK,        8'h00, 7'd1, 7'd2},
      '{mfq_pkg::ACT_GET, 8'h7F, 1'b0, 12'hFFF, 1'b1, mfq_pkg::ST_DATA,      8'h80, 7'd1, 7'd1},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b1, 12'h800, 1'b1, mfq_pkg::ST_DATA,      8'h01, 7'd1, 7'd0},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'h000, 1'b1, mfq_pkg::ST_EMPTY,     8'h00, 7'd0, 7'd0},
      '{mfq_pkg::ACT_PUT, 8'h3C, 1'b1, 12'h000, 1'b1, mfq_pkg::ST_OK,        8'h00, 7'd1, 7'd1},
      '{mfq_pkg::ACT_GET, 8'h00, 1'b0, 12'hFFF, 1'b0, mfq_pkg::ST_DATA,      8'h00, 7'd0, 7'd0}
    };
    for (int i = 0; i < DIR_ROWS; i++) begin
      w.action = directed_rows[i].act;
      w.data_byte = directed_rows[i].data;
      w.last_byte = directed_rows[i].last;
      w.out_capacity = directed_rows[i].cap;
      resp.status = directed_rows[i].st;
      resp.out_byte = directed_rows[i].obyte;
      resp.end_of_run = 1'b1;
      resp.message_length = directed_rows[i].len;
      resp.messages_held = directed_rows[i].held;
      queue_word(w, directed_rows[i].fixed, resp);
    end

    // The queue is empty here: fill the length ring, overflow it with a long
    // and a short message, try a short reader, then drain it past empty.
    repeat (RING_SIZE) queue_message(1, 1'b0);
    queue_message(3, 1'b0);
    queue_message(1, 1'b0);
    queue_word(make_get(0), 1'b0, '0);
    queue_drain(RING_SIZE + 2, 4095);

    // Random traffic: mostly whole messages and gets, some loose put words.
    while (send_queue.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          len = $urandom_range(1, 8);
        else if (sel < 85)
          len = $urandom_range(9, MSG_MAX - 1);
        else if (sel < 90)
          len = MSG_MAX;
        else
          len = $urandom_range(MSG_MAX + 1, MSG_MAX + 6);
        queue_message(len, $urandom_range(0, 99) < 20);
      end else if (pick < 90) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          cap = $urandom_range(MSG_MAX, 4095);
        else if (sel < 85)
          cap = $urandom_range(0, 8);
        else
          cap = $urandom_range(0, 4095);
        queue_word(make_get(cap), 1'b0, '0);
      end else begin
        queue_word(make_put(mfq_pkg::BYTE_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))), 1'b0, '0);
      end
    end

    total_words = send_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Run until every word is sent and answered, or until the link goes quiet.
    while ((send_queue.size() != 0 || awaited_responses.size() != 0) &&
           quiet_cycles < QUIET_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (awaited_responses.size() != 0) begin
        error_count += awaited_responses.size();
        $display("%0d expected result words never arrived", awaited_responses.size());
      end
      if (error_count == 0)
        $display("*** PASSED ***");
      else
        $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
